### rtl/pts_pkg.sv
// Shared types and constants for the packet traffic statistics block.
package pts_pkg;

    localparam int CNT_W = 64;
    localparam int DEN_W = 6;

    localparam logic [1:0]  OP_PKT    = 2'd0;
    localparam logic [1:0]  OP_ENTRY  = 2'd1;
    localparam logic [1:0]  OP_AVG    = 2'd2;
    localparam logic [1:0]  OP_UNUSED = 2'd3;
    localparam logic [15:0] ETH_IPV4  = 16'h0800;

    // register index 0 of the config space
    localparam logic REG_START_SECONDS = 1'b0;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [31:0] now_seconds;
        logic [15:0] eth_type;
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [15:0] pkt_len;
        logic [7:0]  entry_index;
        logic [5:0]  avg_span;
    } t_in;

    typedef struct packed {
        logic [63:0] byte_count;
        logic [63:0] peak_slot_bytes;
        logic [63:0] current_slot_bytes;
        logic        src_counted;
        logic        dst_counted;
        logic        entry_valid;
        logic [31:0] entry_addr;
        logic [63:0] entry_bytes;
        logic [63:0] avg_bytes;
        logic [8:0]  entries_used;
    } t_out;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ADV,
        ST_ADD,
        ST_PEAK,
        ST_SCAN,
        ST_UPD_RD,
        ST_UPD_WR,
        ST_INS,
        ST_ENT_RD,
        ST_SUM,
        ST_DIV,
        ST_DONE
    } t_state;

endpackage

### rtl/pts_div.sv
// Bit-serial restoring divider: 64-bit dividend by 6-bit divisor, one bit per cycle.
module pts_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [pts_pkg::CNT_W-1:0]  i_dividend,
    input  logic [pts_pkg::DEN_W-1:0]  i_divisor,
    output logic                       o_busy,
    output logic [pts_pkg::CNT_W-1:0]  o_quot
);
    import pts_pkg::*;

    localparam int STW = $clog2(CNT_W + 1);

    logic [DEN_W-1:0] r_den;
    logic [DEN_W-1:0] r_rem;
    logic [CNT_W-1:0] r_q;
    logic [STW-1:0]   r_cnt;
    logic [DEN_W:0]   w_trial;
    logic             w_ge;

    assign w_trial = {r_rem, r_q[CNT_W-1]};
    assign w_ge    = w_trial >= {1'b0, r_den};
    assign o_busy  = r_cnt != '0;
    assign o_quot  = r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= STW'(CNT_W);
        end else if (o_busy) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_den <= i_divisor;
            r_rem <= '0;
            r_q   <= i_dividend;
        end else if (o_busy) begin
            r_rem <= w_ge ? DEN_W'(w_trial - {1'b0, r_den}) : DEN_W'(w_trial);
            r_q   <= {r_q[CNT_W-2:0], w_ge};
        end
    end

endmodule

### rtl/packet_traffic_statistics_top.sv
// Top level of the packet traffic statistics block: sequencer, tables and config port.
//
// One item is taken at a time; o_in_stall stays high from acceptance until its result
// beat has been taken. A counted IPv4 packet first clears min(elapsed seconds,
// WINDOW_SLOTS) slots of the slot ring, one slot per cycle, and each of the two
// address lookups then walks the address table one entry per cycle through its
// single read port. An average query sums min(avg_span, WINDOW_SLOTS) slots one
// per cycle and then runs a bit-serial divide. Reset needs no clearing pass: slot
// contents are masked by per-slot valid bits and table entries at or above the fill
// count are never used. Writing start_seconds (address 0) also reloads the last
// update time.
module packet_traffic_statistics_top #(
    parameter int WINDOW_SLOTS  = 40,
    parameter int TABLE_ENTRIES = 256
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  pts_pkg::t_in   i_in,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output pts_pkg::t_out  o_out,
    input  logic           psel,
    input  logic           penable,
    input  logic           pwrite,
    input  logic [2:0]     paddr,
    input  logic [31:0]    pwdata,
    output logic [31:0]    prdata,
    output logic           pready
);
    import pts_pkg::*;

    localparam int SW = $clog2(WINDOW_SLOTS);
    localparam int IW = $clog2(TABLE_ENTRIES);
    localparam int FW = $clog2(TABLE_ENTRIES + 1);
    localparam int EW = (FW > 8) ? FW : 8;

    t_state r_state, n_state;
    t_in    r_item;
    t_out   r_out;
    logic   r_out_vld;

    logic [31:0] r_start, r_last;
    logic [SW-1:0] r_ptr, r_sidx;
    logic [SW:0]   r_steps, r_scnt;
    logic [63:0] r_total, r_peak, r_cur, r_sum;
    logic [FW-1:0] r_fill, r_idx, r_pidx;
    logic [31:0] r_key;
    logic r_pend, r_phase, r_src_ok, r_dst_ok, r_ent_vld, r_spend, r_avg_op;

    // slot ring storage
    logic [63:0] r_slots [WINDOW_SLOTS];
    logic [WINDOW_SLOTS-1:0] r_slot_vld;
    logic [63:0] r_slot_q;
    logic        r_slot_vq;
    logic        w_slot_we;
    logic [SW-1:0] w_slot_wa;
    logic [63:0] w_slot_wd;

    // address table storage
    logic [31:0] r_tab_addr [TABLE_ENTRIES];
    logic [63:0] r_tab_cnt  [TABLE_ENTRIES];
    logic [31:0] r_ta_q;
    logic [63:0] r_tc_q;
    logic [IW-1:0] w_tab_ra, w_tab_wa;
    logic w_addr_we, w_cnt_we;
    logic [63:0] w_cnt_wd;

    logic w_accept, w_hit, w_more, w_full, w_div_start, w_div_busy;
    logic [31:0] w_d;
    logic [SW-1:0] w_ptr_inc;
    logic [63:0] w_quot, w_new_cur;

    assign w_accept  = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != ST_IDLE) || r_out_vld;
    assign o_out_valid = r_out_vld;
    assign o_out       = r_out;
    assign pready      = 1'b1;
    assign prdata      = (paddr[2] == REG_START_SECONDS) ? r_start : 32'd0;

    assign w_d       = i_in.now_seconds - r_last;
    assign w_ptr_inc = (r_ptr == SW'(WINDOW_SLOTS - 1)) ? '0 : r_ptr + 1'b1;
    assign w_hit     = r_pend && (r_ta_q == r_key);
    assign w_more    = r_idx < r_fill;
    assign w_full    = r_fill == FW'(TABLE_ENTRIES);
    assign w_new_cur = r_cur + {48'd0, r_item.pkt_len};

    pts_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (r_sum),
        .i_divisor  (r_item.avg_span),
        .o_busy     (w_div_busy),
        .o_quot     (w_quot)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    if (i_in.opcode == OP_PKT && i_in.eth_type == ETH_IPV4) begin
                        n_state = (w_d != 32'd0 && !w_d[31]) ? ST_ADV : ST_ADD;
                    end else if (i_in.opcode == OP_ENTRY) begin
                        n_state = ST_ENT_RD;
                    end else if (i_in.opcode == OP_AVG && i_in.avg_span != '0) begin
                        n_state = ST_SUM;
                    end else begin
                        n_state = ST_DONE;
                    end
                end
            end
            ST_ADV:    n_state = (r_steps == (SW+1)'(1)) ? ST_ADD : ST_ADV;
            ST_ADD:    n_state = ST_PEAK;
            ST_PEAK:   n_state = ST_SCAN;
            ST_SCAN: begin
                if (w_hit) begin
                    n_state = ST_UPD_RD;
                end else if (!w_more) begin
                    n_state = ST_INS;
                end
            end
            ST_UPD_RD: n_state = ST_UPD_WR;
            ST_UPD_WR: n_state = r_phase ? ST_DONE : ST_SCAN;
            ST_INS:    n_state = r_phase ? ST_DONE : ST_SCAN;
            ST_ENT_RD: n_state = ST_DONE;
            ST_SUM:    n_state = (r_scnt == '0 && !r_spend) ? ST_DIV : ST_SUM;
            ST_DIV:    n_state = w_div_busy ? ST_DIV : ST_DONE;
            ST_DONE:   n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // memory controls
    always_comb begin
        w_slot_we   = 1'b0;
        w_slot_wa   = r_ptr;
        w_slot_wd   = '0;
        w_tab_ra    = r_idx[IW-1:0];
        w_tab_wa    = r_pidx[IW-1:0];
        w_addr_we   = 1'b0;
        w_cnt_we    = 1'b0;
        w_cnt_wd    = r_tc_q + {48'd0, r_item.pkt_len};
        w_div_start = 1'b0;
        case (r_state)
            ST_ADV: begin
                w_slot_we = 1'b1;
                w_slot_wa = w_ptr_inc;
            end
            ST_ADD: begin
                w_slot_we = 1'b1;
                w_slot_wd = w_new_cur;
            end
            ST_UPD_RD: w_tab_ra = r_pidx[IW-1:0];
            ST_UPD_WR: w_cnt_we = 1'b1;
            ST_INS: begin
                w_tab_wa  = r_fill[IW-1:0];
                w_addr_we = !w_full;
                w_cnt_we  = !w_full;
                w_cnt_wd  = {48'd0, r_item.pkt_len};
            end
            ST_ENT_RD: w_tab_ra = IW'(r_item.entry_index);
            ST_SUM:    w_div_start = (r_scnt == '0 && !r_spend);
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_slot_we) begin
            r_slots[w_slot_wa] <= w_slot_wd;
        end
        r_slot_q  <= r_slots[r_sidx];
        r_slot_vq <= r_slot_vld[r_sidx];
    end

    always_ff @(posedge i_clk) begin
        if (w_addr_we) begin
            r_tab_addr[w_tab_wa] <= r_key;
        end
        if (w_cnt_we) begin
            r_tab_cnt[w_tab_wa] <= w_cnt_wd;
        end
        r_ta_q <= r_tab_addr[w_tab_ra];
        r_tc_q <= r_tab_cnt[w_tab_ra];
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_out_vld  <= 1'b0;
            r_start    <= '0;
            r_last     <= '0;
            r_ptr      <= '0;
            r_total    <= '0;
            r_peak     <= '0;
            r_cur      <= '0;
            r_fill     <= '0;
            r_slot_vld <= '0;
        end else begin
            r_state <= n_state;
            if (psel && penable && pwrite && paddr[2] == REG_START_SECONDS) begin
                r_start <= pwdata;
                r_last  <= pwdata;
            end
            if (w_slot_we) begin
                r_slot_vld[w_slot_wa] <= 1'b1;
            end
            if (r_state == ST_IDLE && n_state == ST_ADV) begin
                r_last <= i_in.now_seconds;
            end
            if (r_state == ST_ADV) begin
                r_ptr <= w_ptr_inc;
                r_cur <= '0;
            end
            if (r_state == ST_ADD) begin
                r_cur   <= w_new_cur;
                r_total <= r_total + {48'd0, r_item.pkt_len};
            end
            if (r_state == ST_PEAK && r_cur > r_peak) begin
                r_peak <= r_cur;
            end
            if (r_state == ST_INS && !w_full) begin
                r_fill <= r_fill + 1'b1;
            end
            if (r_state == ST_DONE) begin
                r_out_vld <= 1'b1;
            end else if (r_out_vld && !i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // per-item datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_item    <= i_in;
                r_src_ok  <= 1'b0;
                r_dst_ok  <= 1'b0;
                r_phase   <= 1'b0;
                r_key     <= i_in.src_addr;
                r_idx     <= '0;
                r_pend    <= 1'b0;
                r_spend   <= 1'b0;
                r_sum     <= '0;
                r_sidx    <= r_ptr;
                r_avg_op  <= i_in.opcode == OP_AVG;
                r_ent_vld <= i_in.opcode == OP_ENTRY &&
                             EW'(i_in.entry_index) < EW'(r_fill);
                r_steps   <= (w_d < 32'(WINDOW_SLOTS)) ? w_d[SW:0] : (SW+1)'(WINDOW_SLOTS);
                r_scnt    <= ({1'b0, i_in.avg_span} < 7'(WINDOW_SLOTS)) ?
                             (SW+1)'(i_in.avg_span) : (SW+1)'(WINDOW_SLOTS);
            end
            ST_ADV: r_steps <= r_steps - 1'b1;
            ST_SCAN: begin
                if (!w_hit) begin
                    r_pend <= w_more;
                    if (w_more) begin
                        r_pidx <= r_idx;
                        r_idx  <= r_idx + 1'b1;
                    end
                end
            end
            ST_UPD_WR, ST_INS: begin
                if (r_phase) begin
                    r_dst_ok <= (r_state == ST_UPD_WR) || !w_full;
                end else begin
                    r_src_ok <= (r_state == ST_UPD_WR) || !w_full;
                end
                r_phase <= 1'b1;
                r_key   <= r_item.dst_addr;
                r_idx   <= '0;
                r_pend  <= 1'b0;
            end
            ST_SUM: begin
                r_spend <= r_scnt != '0;
                if (r_scnt != '0) begin
                    r_scnt <= r_scnt - 1'b1;
                    r_sidx <= (r_sidx == '0) ? SW'(WINDOW_SLOTS - 1) : r_sidx - 1'b1;
                end
                if (r_spend) begin
                    r_sum <= r_sum + (r_slot_vq ? r_slot_q : 64'd0);
                end
            end
            ST_DONE: begin
                r_out.byte_count         <= r_total;
                r_out.peak_slot_bytes    <= r_peak;
                r_out.current_slot_bytes <= r_cur;
                r_out.src_counted        <= r_src_ok;
                r_out.dst_counted        <= r_dst_ok;
                r_out.entry_valid        <= r_ent_vld;
                r_out.entry_addr         <= r_ent_vld ? r_ta_q : 32'd0;
                r_out.entry_bytes        <= r_ent_vld ? r_tc_q : 64'd0;
                r_out.avg_bytes          <= (r_avg_op && r_item.avg_span != '0) ?
                                            w_quot : 64'd0;
                r_out.entries_used       <= 9'(r_fill);
            end
            default: ;
        endcase
    end

endmodule
